// ===== hw/rtl/pmtp_pkg.sv =====
// ----------------------------------------------------------------------------
// pmtp_pkg
// Shared types and constants of the PMT section payload parser.
// ----------------------------------------------------------------------------
package pmtp_pkg;

	localparam logic [2:0] KIND_PCR       = 3'd0;
	localparam logic [2:0] KIND_PROG_DESC = 3'd1;
	localparam logic [2:0] KIND_ES        = 3'd2;
	localparam logic [2:0] KIND_ES_DESC   = 3'd3;
	localparam logic [2:0] KIND_DATA      = 3'd4;
	localparam logic [2:0] KIND_DONE      = 3'd5;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = 2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [12:0] pid;
		logic [7:0]  es_type;
		logic [7:0]  tag;
		logic [7:0]  len;
		logic [7:0]  value;
	} rec_t;

	// Everything one byte produces: an optional record, then an optional done record.
	typedef struct packed {
		logic has_rec;
		rec_t rec;
		logic has_done;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} push_t;

endpackage

// ===== hw/rtl/pmtp_front.sv =====
// ----------------------------------------------------------------------------
// pmtp_front
// Byte-level section walker: tracks header, descriptor regions and ES entries,
// and classifies each byte into the records it produces.
// ----------------------------------------------------------------------------
module pmtp_front #(
	parameter int LENGTH_BITS = 12
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            byte_fire,
	input  logic [7:0]      data_byte,
	input  logic            first_byte,
	input  logic [11:0]     payload_length,
	output pmtp_pkg::push_t push
);

	localparam int LW = LENGTH_BITS;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_TAG,
		PH_LEN,
		PH_DATA,
		PH_ES_HEAD,
		PH_TAIL
	} phase_t;

	phase_t        phase_q, ph, ph_n;
	logic          es_q, es, es_n;
	logic [LW-1:0] pos_q, p, pos_n;
	logic [LW-1:0] len_q, len, len_n;
	logic [LW-1:0] rend_q, rend, rend_n;
	logic [7:0]    left_q, left, left_n;
	logic          acc_q, acc, acc_n;
	logic [31:0]   hold_q, hold, hold_n;

	logic [LW-1:0] plen;
	logic [LW:0]   nxt;
	logic [12:0]   pinfo_end;
	logic [13:0]   es_end;
	logic [LW+1:0] desc_end;
	logic [LW-1:0] es_off;
	logic [39:0]   w;
	logic          empty_first;
	pmtp_pkg::entry_t ent;

	assign plen = payload_length[LW-1:0];

	always_comb begin
		ph   = first_byte ? PH_HEADER : phase_q;
		es   = first_byte ? 1'b0 : es_q;
		p    = first_byte ? '0 : pos_q;
		len  = first_byte ? plen : len_q;
		rend = first_byte ? '0 : rend_q;
		left = first_byte ? 8'd0 : left_q;
		acc  = first_byte ? 1'b0 : acc_q;
		hold = first_byte ? 32'd0 : hold_q;

		ph_n   = ph;
		es_n   = es;
		pos_n  = p;
		len_n  = len;
		rend_n = rend;
		left_n = left;
		acc_n  = acc;
		hold_n = hold;

		ent         = '0;
		nxt         = {1'b0, p} + (LW+1)'(1);
		w           = {hold, data_byte};
		pinfo_end   = '0;
		es_end      = '0;
		desc_end    = {2'b00, p} + (LW+2)'(data_byte) + (LW+2)'(1);
		es_off      = p - rend;
		empty_first = first_byte && (plen == '0);

		if (empty_first) begin
			ph_n         = PH_IDLE;
			ent.has_done = 1'b1;
		end else if (ph != PH_IDLE) begin
			case (ph)
				PH_HEADER: begin
					hold_n = {hold[23:0], data_byte};
					if (p == LW'(1)) begin
						ent.has_rec  = 1'b1;
						ent.rec.kind = pmtp_pkg::KIND_PCR;
						ent.rec.pid  = hold_n[12:0];
					end
					if (p >= LW'(3)) begin
						pinfo_end = 13'(hold_n[11:0]) + 13'd4;
						rend_n = (pinfo_end < 13'(len)) ? pinfo_end[LW-1:0] : len;
						ph_n   = PH_TAG;
					end
				end
				PH_TAG: begin
					if (({1'b0, p} + (LW+1)'(2)) <= {1'b0, rend}) begin
						hold_n = {24'd0, data_byte};
						ph_n   = PH_LEN;
					end
				end
				PH_LEN: begin
					acc_n = (desc_end <= {2'b00, rend});
					if (acc_n) begin
						ent.has_rec  = 1'b1;
						ent.rec.kind = es ? pmtp_pkg::KIND_ES_DESC : pmtp_pkg::KIND_PROG_DESC;
						ent.rec.tag  = hold[7:0];
						ent.rec.len  = data_byte;
					end
					left_n = data_byte;
					ph_n   = (data_byte == 8'd0) ? PH_TAG : PH_DATA;
				end
				PH_DATA: begin
					if (left != 8'd0) begin
						if (acc) begin
							ent.has_rec   = 1'b1;
							ent.rec.kind  = pmtp_pkg::KIND_DATA;
							ent.rec.value = data_byte;
						end
						left_n = left - 8'd1;
					end
					if (left_n == 8'd0)
						ph_n = PH_TAG;
				end
				PH_ES_HEAD: begin
					if (es_off < LW'(4)) begin
						hold_n = {hold[23:0], data_byte};
					end else begin
						ent.has_rec      = 1'b1;
						ent.rec.kind     = pmtp_pkg::KIND_ES;
						ent.rec.pid      = w[28:16];
						ent.rec.es_type  = w[39:32];
						es_end = 14'(p) + 14'(w[11:0]) + 14'd1;
						rend_n = (es_end < 14'(len)) ? es_end[LW-1:0] : len;
						ph_n   = PH_TAG;
						es_n   = 1'b1;
					end
				end
				default: begin
				end
			endcase

			pos_n = nxt[LW-1:0];
			if ((ph_n == PH_TAG || ph_n == PH_LEN || ph_n == PH_DATA) &&
			    nxt >= {1'b0, rend_n}) begin
				rend_n = nxt[LW-1:0];
				hold_n = 32'd0;
				es_n   = 1'b0;
				ph_n   = ((nxt + (LW+1)'(5)) <= {1'b0, len}) ? PH_ES_HEAD : PH_TAIL;
			end
			if (nxt >= {1'b0, len}) begin
				ent.has_done = 1'b1;
				ph_n         = PH_IDLE;
			end
		end

		push.valid = byte_fire && (ent.has_rec || ent.has_done);
		push.entry = ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			es_q    <= 1'b0;
			pos_q   <= '0;
			len_q   <= '0;
			rend_q  <= '0;
			left_q  <= 8'd0;
			acc_q   <= 1'b0;
			hold_q  <= 32'd0;
		end else if (byte_fire) begin
			phase_q <= ph_n;
			es_q    <= es_n;
			pos_q   <= pos_n;
			len_q   <= len_n;
			rend_q  <= rend_n;
			left_q  <= left_n;
			acc_q   <= acc_n;
			hold_q  <= hold_n;
		end
	end

endmodule

// ===== hw/rtl/pmtp_queue.sv =====
// ----------------------------------------------------------------------------
// pmtp_queue
// Short first-word-fall-through queue of per-byte record entries.
// ----------------------------------------------------------------------------
module pmtp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  pmtp_pkg::push_t   push,
	output logic              full,
	output logic              head_valid,
	output pmtp_pkg::entry_t  head,
	input  logic              pop
);

	pmtp_pkg::entry_t mem [pmtp_pkg::QUEUE_DEPTH];

	logic [pmtp_pkg::QPTR_BITS-1:0] wr_q, rd_q;
	logic [pmtp_pkg::QPTR_BITS:0]   count_q;
	logic                           do_push, do_pop;

	assign full       = (count_q == (pmtp_pkg::QPTR_BITS+1)'(pmtp_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem[rd_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_q] <= push.entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + (pmtp_pkg::QPTR_BITS)'(1);
			if (do_pop)
				rd_q <= rd_q + (pmtp_pkg::QPTR_BITS)'(1);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (pmtp_pkg::QPTR_BITS+1)'(1);
				2'b01:   count_q <= count_q - (pmtp_pkg::QPTR_BITS+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/pmtp_back.sv =====
// ----------------------------------------------------------------------------
// pmtp_back
// Output stage: takes one entry at a time and delivers its record and its
// done record as separate result transactions.
// ----------------------------------------------------------------------------
module pmtp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  pmtp_pkg::entry_t head,
	output logic             pop,
	output logic             rec_valid,
	input  logic             rec_ready,
	output logic [2:0]       record_kind,
	output logic [12:0]      pid,
	output logic [7:0]       es_type,
	output logic [7:0]       desc_tag,
	output logic [7:0]       desc_len,
	output logic [7:0]       payload_value,
	output logic             section_end
);

	pmtp_pkg::rec_t rec_q;
	logic           rec_pend_q, done_pend_q;
	logic           fire, last;

	assign rec_valid = rec_pend_q || done_pend_q;
	assign fire      = rec_valid && rec_ready;
	assign last      = !(rec_pend_q && done_pend_q);
	assign pop       = head_valid && (!rec_valid || (fire && last));

	assign record_kind   = rec_pend_q ? rec_q.kind : pmtp_pkg::KIND_DONE;
	assign pid           = rec_pend_q ? rec_q.pid : 13'd0;
	assign es_type       = rec_pend_q ? rec_q.es_type : 8'd0;
	assign desc_tag      = rec_pend_q ? rec_q.tag : 8'd0;
	assign desc_len      = rec_pend_q ? rec_q.len : 8'd0;
	assign payload_value = rec_pend_q ? rec_q.value : 8'd0;
	assign section_end   = !rec_pend_q && done_pend_q;

	always_ff @(posedge clk) begin
		if (pop)
			rec_q <= head.rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_pend_q  <= 1'b0;
			done_pend_q <= 1'b0;
		end else if (pop) begin
			rec_pend_q  <= head.has_rec;
			done_pend_q <= head.has_done;
		end else if (fire) begin
			if (rec_pend_q)
				rec_pend_q <= 1'b0;
			else
				done_pend_q <= 1'b0;
		end
	end

endmodule

// ===== hw/rtl/pmt_section_payload_parser.sv =====
// ----------------------------------------------------------------------------
// pmt_section_payload_parser
// PMT section payload parser: PCR PID, program descriptors, ES entries and
// their descriptors, one byte per transaction.
// ----------------------------------------------------------------------------
// The parser takes one payload byte per cycle while the queue has room; the byte
// walker decides in the cycle of acceptance which records the byte yields and
// pushes them as one entry into a four-entry queue. The output stage delivers
// one result per cycle while rec_ready is high, and the last byte of a section
// that also carries a record yields two results. Bytes are accepted whenever the
// queue has room, independent of a stalled result. An accepted byte's entry is
// registered in the queue, then its record in the output stage register.
module pmt_section_payload_parser #(
	parameter int LENGTH_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic [11:0] payload_length,
	output logic        rec_valid,
	input  logic        rec_ready,
	output logic [2:0]  record_kind,
	output logic [12:0] pid,
	output logic [7:0]  es_type,
	output logic [7:0]  desc_tag,
	output logic [7:0]  desc_len,
	output logic [7:0]  payload_value,
	output logic        section_end
);

	pmtp_pkg::push_t  push;
	pmtp_pkg::entry_t head;
	logic             full, head_valid, pop, byte_fire;

	assign byte_ready = !full;
	assign byte_fire  = byte_valid && byte_ready;

	pmtp_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_fire     (byte_fire),
		.data_byte     (data_byte),
		.first_byte    (first_byte),
		.payload_length(payload_length),
		.push          (push)
	);

	pmtp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop)
	);

	pmtp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.rec_valid    (rec_valid),
		.rec_ready    (rec_ready),
		.record_kind  (record_kind),
		.pid          (pid),
		.es_type      (es_type),
		.desc_tag     (desc_tag),
		.desc_len     (desc_len),
		.payload_value(payload_value),
		.section_end  (section_end)
	);

endmodule

// ===== hw/rtl/pmtp_checker.sv =====
// ----------------------------------------------------------------------------
// pmtp_checker
// Port-level checks of the PMT section payload parser, bound to the top level.
// ----------------------------------------------------------------------------
module pmtp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rec_valid,
	input logic        rec_ready,
	input logic [2:0]  record_kind,
	input logic [12:0] pid,
	input logic [7:0]  es_type,
	input logic [7:0]  desc_tag,
	input logic [7:0]  desc_len,
	input logic [7:0]  payload_value,
	input logic        section_end
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && !rec_ready |=> rec_valid && $stable(record_kind) && $stable(pid) &&
		$stable(es_type) && $stable(desc_tag) && $stable(desc_len) &&
		$stable(payload_value) && $stable(section_end))
		else $error("result transaction dropped or changed under stall");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid |-> (section_end == (record_kind == pmtp_pkg::KIND_DONE)))
		else $error("section_end disagrees with record kind");

	a_desc: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && (record_kind == pmtp_pkg::KIND_PROG_DESC ||
		              record_kind == pmtp_pkg::KIND_ES_DESC ||
		              record_kind == pmtp_pkg::KIND_DATA) |-> pid == 13'd0 && es_type == 8'd0)
		else $error("descriptor record carries a pid or stream type");

	a_data: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && (record_kind == pmtp_pkg::KIND_DATA || record_kind == pmtp_pkg::KIND_DONE)
		|-> desc_tag == 8'd0 && desc_len == 8'd0)
		else $error("data or done record carries descriptor header");

endmodule

bind pmt_section_payload_parser pmtp_checker u_pmtp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rec_valid    (rec_valid),
	.rec_ready    (rec_ready),
	.record_kind  (record_kind),
	.pid          (pid),
	.es_type      (es_type),
	.desc_tag     (desc_tag),
	.desc_len     (desc_len),
	.payload_value(payload_value),
	.section_end  (section_end)
);

// ===== tb/sv/pmt_record_checker.sv =====
// ----------------------------------------------------------------------------
// pmt_record_checker
// Watches the byte and record channels of the PMT section payload parser,
// walks every accepted byte through its own copy of the parse state, queues
// the records the byte must yield and compares each delivered record with
// the oldest one queued.
// ----------------------------------------------------------------------------
module pmt_record_checker #(
	parameter int LENGTH_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	input  logic        byte_ready,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic [11:0] payload_length,
	input  logic        rec_valid,
	input  logic        rec_ready,
	input  logic [2:0]  record_kind,
	input  logic [12:0] pid,
	input  logic [7:0]  es_type,
	input  logic [7:0]  desc_tag,
	input  logic [7:0]  desc_len,
	input  logic [7:0]  payload_value,
	input  logic        section_end,
	output int          fail_count,
	output int          expected_left
);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_HEADER  = 4'd1;
	localparam logic [3:0] ST_TAG     = 4'd2;
	localparam logic [3:0] ST_LEN     = 4'd3;
	localparam logic [3:0] ST_DATA    = 4'd4;
	localparam logic [3:0] ST_ES_HEAD = 4'd5;
	localparam logic [3:0] ST_TAIL    = 4'd6;
	localparam logic [3:0] ST_IN_ES   = 4'd8;

	typedef struct packed {
		logic [2:0]  kind;
		logic [12:0] pid;
		logic [7:0]  es_type;
		logic [7:0]  tag;
		logic [7:0]  len;
		logic [7:0]  value;
		logic        last;
	} pmt_record_t;

	pmt_record_t expected_recs[$];
	pmt_record_t seen;
	pmt_record_t want;
	int          failures;

	logic [3:0]  phase;
	int unsigned pos;
	int unsigned sect_len;
	int unsigned region_end;
	int unsigned desc_left;
	logic        desc_ok;
	logic [31:0] hdr_window;

	function automatic pmt_record_t record_of(input logic [2:0] kind, input logic [12:0] pid_v,
			input logic [7:0] st, input logic [7:0] tag, input logic [7:0] len,
			input logic [7:0] value, input logic last);
		pmt_record_t r;
		r.kind    = kind;
		r.pid     = pid_v;
		r.es_type = st;
		r.tag     = tag;
		r.len     = len;
		r.value   = value;
		r.last    = last;
		return r;
	endfunction

	function automatic string show(input pmt_record_t r);
		return $sformatf("kind %0d pid %h type %h tag %h len %h value %h end %b",
			r.kind, r.pid, r.es_type, r.tag, r.len, r.value, r.last);
	endfunction

	function automatic int unsigned clip_to_section(input int unsigned e);
		return (e < sect_len) ? e : sect_len;
	endfunction

	task automatic walk_byte(input logic [7:0] b, input logic first, input logic [11:0] plen);
		int unsigned lenm;
		int unsigned p;
		int unsigned nxt;
		int unsigned eil;
		logic [3:0]  base;
		logic [3:0]  in_es;
		logic [39:0] w;
		lenm = (1 << LENGTH_BITS) - 1;
		if (first) begin
			sect_len   = plen & lenm;
			pos        = 0;
			region_end = 0;
			desc_left  = 0;
			desc_ok    = 1'b0;
			hdr_window = '0;
			if (sect_len == 0) begin
				phase = ST_IDLE;
				expected_recs.push_back(record_of(pmtp_pkg::KIND_DONE, '0, '0, '0, '0, '0,
					1'b1));
				return;
			end
			phase = ST_HEADER;
		end
		if (phase == ST_IDLE)
			return;

		p     = pos;
		base  = phase & 4'd7;
		in_es = phase & ST_IN_ES;

		case (base)
			ST_HEADER: begin
				hdr_window = {hdr_window[23:0], b};
				if (p == 1)
					expected_recs.push_back(record_of(pmtp_pkg::KIND_PCR, hdr_window[12:0],
						'0, '0, '0, '0, 1'b0));
				if (p >= 3) begin
					region_end = clip_to_section(4 + hdr_window[11:0]);
					phase      = ST_TAG;
				end
			end
			ST_TAG: begin
				if (p + 2 <= region_end) begin
					hdr_window = {24'd0, b};
					phase      = ST_LEN | in_es;
				end
			end
			ST_LEN: begin
				desc_ok = (p + 1 + b <= region_end);
				if (desc_ok)
					expected_recs.push_back(record_of((in_es != 0) ? pmtp_pkg::KIND_ES_DESC
						: pmtp_pkg::KIND_PROG_DESC, '0, '0, hdr_window[7:0], b, '0, 1'b0));
				desc_left = b;
				phase     = (b == 0) ? (ST_TAG | in_es) : (ST_DATA | in_es);
			end
			ST_DATA: begin
				if (desc_left != 0) begin
					if (desc_ok)
						expected_recs.push_back(record_of(pmtp_pkg::KIND_DATA, '0, '0, '0, '0,
							b, 1'b0));
					desc_left--;
				end
				if (desc_left == 0)
					phase = ST_TAG | in_es;
			end
			ST_ES_HEAD: begin
				if (p - region_end < 32'd4) begin
					hdr_window = {hdr_window[23:0], b};
				end else begin
					w   = {hdr_window, b};
					eil = w[11:0];
					expected_recs.push_back(record_of(pmtp_pkg::KIND_ES, w[28:16], w[39:32],
						'0, '0, '0, 1'b0));
					region_end = clip_to_section(p + 1 + eil);
					phase      = ST_TAG | ST_IN_ES;
				end
			end
			default: ;
		endcase

		nxt  = p + 1;
		pos  = nxt & lenm;
		base = phase & 4'd7;
		if ((base == ST_TAG || base == ST_LEN || base == ST_DATA) && nxt >= region_end) begin
			region_end = nxt & lenm;
			hdr_window = '0;
			phase      = (nxt + 5 <= sect_len) ? ST_ES_HEAD : ST_TAIL;
		end
		if (nxt >= sect_len) begin
			expected_recs.push_back(record_of(pmtp_pkg::KIND_DONE, '0, '0, '0, '0, '0, 1'b1));
			phase = ST_IDLE;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			phase      = ST_IDLE;
			pos        = 0;
			sect_len   = 0;
			region_end = 0;
			desc_left  = 0;
			desc_ok    = 1'b0;
			hdr_window = '0;
			expected_recs.delete();
		end else begin
			if (rec_valid && rec_ready) begin
				seen = record_of(record_kind, pid, es_type, desc_tag,
					desc_len, payload_value, section_end);
				if (expected_recs.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("unexpected record: %s", show(seen));
				end else begin
					want = expected_recs.pop_front();
					if (seen.kind !== want.kind || seen.pid !== want.pid
							|| seen.es_type !== want.es_type || seen.tag !== want.tag
							|| seen.len !== want.len || seen.value !== want.value
							|| seen.last !== want.last) begin
						failures++;
						if (failures <= 10)
							$display("record mismatch: expected %s, got %s", show(want), show(seen));
					end
				end
			end
			if (byte_valid && byte_ready)
				walk_byte(data_byte, first_byte, payload_length);
		end
		fail_count    <= failures;
		expected_left <= expected_recs.size();
	end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives PMT section payloads into the parser: a few hand-built sections,
// then random well-formed sections with random content mixed with aborted
// sections, garbage and stray bytes, under several sender and receiver
// throttling phases. Record checking is done by pmt_record_checker.
// ----------------------------------------------------------------------------
module tb;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        byte_valid     = 1'b0;
	logic        byte_ready;
	logic [7:0]  data_byte      = 8'd0;
	logic        first_byte     = 1'b0;
	logic [11:0] payload_length = 12'd0;
	logic        rec_valid;
	logic        rec_ready      = 1'b0;
	logic [2:0]  record_kind;
	logic [12:0] pid;
	logic [7:0]  es_type;
	logic [7:0]  desc_tag;
	logic [7:0]  desc_len;
	logic [7:0]  payload_value;
	logic        section_end;
	int          fail_count;
	int          expected_left;

	int          send_idle_pct = 0;
	int          stall_pct     = 0;
	int          items_sent    = 0;
	int          section_plen;
	logic [7:0]  section_bytes[$];

	pmt_section_payload_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_ready    (byte_ready),
		.data_byte     (data_byte),
		.first_byte    (first_byte),
		.payload_length(payload_length),
		.rec_valid     (rec_valid),
		.rec_ready     (rec_ready),
		.record_kind   (record_kind),
		.pid           (pid),
		.es_type       (es_type),
		.desc_tag      (desc_tag),
		.desc_len      (desc_len),
		.payload_value (payload_value),
		.section_end   (section_end)
	);

	pmt_record_checker u_record_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_ready    (byte_ready),
		.data_byte     (data_byte),
		.first_byte    (first_byte),
		.payload_length(payload_length),
		.rec_valid     (rec_valid),
		.rec_ready     (rec_ready),
		.record_kind   (record_kind),
		.pid           (pid),
		.es_type       (es_type),
		.desc_tag      (desc_tag),
		.desc_len      (desc_len),
		.payload_value (payload_value),
		.section_end   (section_end),
		.fail_count    (fail_count),
		.expected_left (expected_left)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(255));
	endfunction

	task automatic offer_byte(input logic [7:0] b, input logic first, input logic [11:0] plen);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid     <= 1'b1;
		data_byte      <= b;
		first_byte     <= first;
		payload_length <= plen;
		do
			@(posedge clk);
		while (!byte_ready);
		@(negedge clk);
	endtask

	task automatic send_section(input int plen);
		logic [11:0] noise;
		for (int i = 0; i < section_bytes.size(); i++) begin
			noise = 12'($urandom_range(4095));
			offer_byte(section_bytes[i], i == 0, (i == 0) ? plen[11:0] : noise);
		end
		items_sent += section_bytes.size();
	endtask

	// Fills exactly region bytes with descriptors; a few overflow, a last single byte is left lone.
	task automatic put_descriptors(input int region);
		int left;
		int len_max;
		int dlen;
		left = region;
		while (left >= 2) begin
			len_max = (left - 2 > 255) ? 255 : left - 2;
			if ($urandom_range(19) == 0) begin
				dlen = len_max + $urandom_range(1, 8);
				if (dlen > 255)
					dlen = 255;
			end else if ($urandom_range(3) == 0) begin
				dlen = len_max;
			end else begin
				dlen = $urandom_range(0, (len_max < 6) ? len_max : 6);
			end
			section_bytes.push_back(rand_byte());
			section_bytes.push_back(dlen[7:0]);
			left -= 2;
			for (int i = 0; i < dlen && left > 0; i++) begin
				section_bytes.push_back(rand_byte());
				left--;
			end
		end
		if (left == 1)
			section_bytes.push_back(rand_byte());
	endtask

	task automatic build_pmt();
		int          pil;
		int          eil;
		int          n_es;
		int          plen;
		logic [12:0] pid13;
		logic [11:0] len12;
		logic [2:0]  r3;
		logic [3:0]  r4;
		section_bytes.delete();
		pil   = ($urandom_range(39) == 0) ? 257 : $urandom_range(0, 12);
		pid13 = 13'($urandom_range(8191));
		len12 = ($urandom_range(9) == 0) ? 12'($urandom_range(4095)) : pil[11:0];
		r3    = 3'($urandom_range(7));
		r4    = 4'($urandom_range(15));
		section_bytes.push_back({r3, pid13[12:8]});
		section_bytes.push_back(pid13[7:0]);
		section_bytes.push_back({r4, len12[11:8]});
		section_bytes.push_back(len12[7:0]);
		put_descriptors(pil);
		n_es = $urandom_range(0, 3);
		repeat (n_es) begin
			eil   = $urandom_range(0, 10);
			pid13 = 13'($urandom_range(8191));
			len12 = ($urandom_range(9) == 0) ? 12'($urandom_range(4095)) : eil[11:0];
			r3    = 3'($urandom_range(7));
			r4    = 4'($urandom_range(15));
			section_bytes.push_back(rand_byte());
			section_bytes.push_back({r3, pid13[12:8]});
			section_bytes.push_back(pid13[7:0]);
			section_bytes.push_back({r4, len12[11:8]});
			section_bytes.push_back(len12[7:0]);
			put_descriptors(eil);
		end
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 4))
				section_bytes.push_back(rand_byte());
		plen = section_bytes.size();
		if ($urandom_range(5) == 0)
			plen = plen + $urandom_range(0, 8) - 4;
		if (plen < 0)
			plen = 0;
		section_plen = plen;
	endtask

	// Receiver: long hold-off right after reset, then random stalls.
	initial begin
		@(posedge arst_n);
		repeat (400) begin
			@(negedge clk);
			rec_ready <= 1'b0;
		end
		forever begin
			@(negedge clk);
			rec_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		int roll;
		int n;
		int waited;
		logic [11:0] noise;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// stray byte before any section
		offer_byte(8'hFF, 1'b0, 12'hFFF);
		// empty payload
		section_bytes = '{8'hFF};
		send_section(0);
		// short headers
		send_section(1);
		section_bytes = '{8'hFF, 8'hFF};
		send_section(2);
		// accepted program descriptor, lone byte, ES entry with a zero-length descriptor
		section_bytes = '{8'hE0, 8'h00, 8'hF0, 8'h04, 8'h00, 8'h01, 8'hFF, 8'h77,
			8'hFF, 8'hFF, 8'hFF, 8'hF0, 8'h02, 8'hFF, 8'h00};
		send_section(15);
		// overflowing descriptor, then trailing bytes
		section_bytes = '{8'h00, 8'h00, 8'h00, 8'h03, 8'h01, 8'hC8, 8'h55, 8'h12, 8'h34};
		send_section(9);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 84; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 84; end
				default: begin send_idle_pct = 19; stall_pct = 19; end
			endcase
			while (items_sent < 30 + 270 * (ph + 1)) begin
				roll = $urandom_range(99);
				if (roll < 72) begin
					build_pmt();
					send_section(section_plen);
				end else if (roll < 84) begin
					// long declared length, cut short by the next section
					section_bytes.delete();
					repeat ($urandom_range(1, 8))
						section_bytes.push_back(rand_byte());
					send_section($urandom_range(4095));
				end else if (roll < 94) begin
					section_bytes.delete();
					n = $urandom_range(1, 20);
					repeat (n)
						section_bytes.push_back(rand_byte());
					send_section($urandom_range(0, n + 2));
				end else begin
					repeat ($urandom_range(1, 3)) begin
						noise = 12'($urandom_range(4095));
						offer_byte(rand_byte(), 1'b0, noise);
					end
				end
			end
		end
		byte_valid <= 1'b0;

		waited = 0;
		while (expected_left != 0 && waited < 50000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (expected_left != 0)
			$display("%0d expected records never delivered", expected_left);
		if (fail_count == 0 && expected_left == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
